>>> src/sca_pkg.sv
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Shared widths, status and operation codes, register map and reset limits.
// ----------------------------------------------------------------------------
package sca_pkg;

	localparam int NUM_POOLS       = 4;
	localparam int POOL_W          = 2;
	localparam int SIZE_W          = 12;
	localparam int FIDX_W          = 6;
	localparam int DEF_POOL_BLOCKS = 64;

	typedef logic [SIZE_W-1:0] bytes_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_BLOCK  = 2'd1,
		ST_NOT_ALLOC = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [POOL_W-1:0] {
		REG_POOL0_BYTES = 2'd0,
		REG_POOL1_BYTES = 2'd1,
		REG_POOL2_BYTES = 2'd2,
		REG_POOL3_BYTES = 2'd3
	} cfg_reg_t;

	localparam bytes_t LIMIT_RESET [NUM_POOLS] = '{12'd16, 12'd32, 12'd48, 12'd64};

endpackage

>>> src/sca_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Allocate or free request with valid/ready transfer.
// ----------------------------------------------------------------------------
interface sca_req_if
	import sca_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [SIZE_W-1:0]   request_size;
	logic [POOL_W-1:0]   free_pool;
	logic [FIDX_W-1:0]   free_index;

	modport source (output valid, operation, request_size, free_pool, free_index, input ready);
	modport sink   (input valid, operation, request_size, free_pool, free_index, output ready);
endinterface

>>> src/sca_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// One result per request with valid/ready transfer.
// ----------------------------------------------------------------------------
interface sca_rsp_if
	import sca_pkg::*;
();
	logic                valid;
	logic                ready;
	status_t             status;
	logic [POOL_W-1:0]   granted_pool;
	logic [FIDX_W-1:0]   granted_index;

	modport source (output valid, status, granted_pool, granted_index, input ready);
	modport sink   (input valid, status, granted_pool, granted_index, output ready);
endinterface

>>> src/sca_cfg_if.sv
// ----------------------------------------------------------------------------
// Allocator configuration channel
// Register write transfer: register index and write data.
// ----------------------------------------------------------------------------
interface sca_cfg_if
	import sca_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [POOL_W-1:0]   index;
	logic [SIZE_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/sca_queue_bank.sv
// ----------------------------------------------------------------------------
// Free list bank
// One pool's circular free list RAM with a registered front read. Slots not
// yet written since reset read as their own slot number.
// ----------------------------------------------------------------------------
module sca_queue_bank
	import sca_pkg::*;
#(
	parameter int POOL_BLOCKS = DEF_POOL_BLOCKS,
	localparam int IDX_W = $clog2(POOL_BLOCKS)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	input  logic             rinit,
	output logic [IDX_W-1:0] rdata
);

	logic [IDX_W-1:0] mem_q [POOL_BLOCKS];
	logic [IDX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rinit) begin
			rdata_q <= raddr;
		end else if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/sca_mark_mem.sv
// ----------------------------------------------------------------------------
// Allocated mark store
// One mark per addressable block, write-through registered read, valid bits
// cleared at reset so unwritten entries read as clear.
// ----------------------------------------------------------------------------
module sca_mark_mem
	import sca_pkg::*;
#(
	parameter int ADDR_W = POOL_W + FIDX_W,
	localparam int DEPTH = 2 ** ADDR_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic              wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic              rdata
);

	logic             mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic             rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= valid_q[raddr] && mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// Size-class block allocator
// Four pools of fixed-size blocks, each with a FIFO free list and allocated
// marks; allocate takes the first fitting pool with a free block.
//
//   channel | dir | payload
//   req     | in  | operation, request_size, free_pool, free_index
//   rsp     | out | status, granted_pool, granted_index
//   cfg     | in  | index (pool limit register), data (12-bit limit)
//
// One request per cycle while rsp is not stalled; a request transfers into the
// request register and is processed from there into the result register.
// The pool-fit compare, free list pointer update and mark lookup of one
// request all sit between the request register and the result register.
// Reset loads the limits 16/32/48/64 and full free lists with no clearing
// pass: unwritten free list slots read as their own slot number.
// A stalled rsp holds the request register, which then holds req.ready low.
// ----------------------------------------------------------------------------
module size_class_block_allocator
	import sca_pkg::*;
#(
	parameter int POOL_BLOCKS = DEF_POOL_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	sca_req_if.sink     req,
	sca_rsp_if.source   rsp,
	sca_cfg_if.sink     cfg
);

	localparam int IDX_W       = $clog2(POOL_BLOCKS);
	localparam int CNT_W       = $clog2(POOL_BLOCKS + 1);
	localparam int MARK_BLOCKS = (POOL_BLOCKS < 2 ** FIDX_W) ? POOL_BLOCKS : 2 ** FIDX_W;
	localparam int MARK_W      = $clog2(MARK_BLOCKS);
	localparam int MADDR_W     = POOL_W + MARK_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(POOL_BLOCKS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(POOL_BLOCKS);

	// request register
	logic                s1_valid_q;
	op_t                 op_s1;
	bytes_t              size_s1;
	logic [POOL_W-1:0]   pool_s1;
	logic [FIDX_W-1:0]   idx_s1;

	// pool state
	bytes_t              limit_q [NUM_POOLS];
	logic [IDX_W-1:0]    head_q  [NUM_POOLS];
	logic [IDX_W-1:0]    tail_q  [NUM_POOLS];
	logic [CNT_W-1:0]    count_q [NUM_POOLS];
	logic [NUM_POOLS-1:0] wrap_q;

	// result register
	logic                rsp_valid_q;
	status_t             status_q;
	logic [POOL_W-1:0]   gpool_q;
	logic [FIDX_W-1:0]   gidx_q;

	logic                accept;
	logic                advance;
	logic [NUM_POOLS-1:0] fit;
	logic                any_fit;
	logic [POOL_W-1:0]   pick;
	logic [IDX_W-1:0]    front   [NUM_POOLS];
	logic [IDX_W-1:0]    blk;
	logic                fidx_ok;
	logic                blk_marked;
	logic                mark_rd;
	logic                free_ok;
	logic [NUM_POOLS-1:0] pop_en;
	logic [NUM_POOLS-1:0] push_en;
	logic [IDX_W-1:0]    head_d  [NUM_POOLS];
	logic [IDX_W-1:0]    tail_d  [NUM_POOLS];
	logic [CNT_W-1:0]    count_d [NUM_POOLS];
	logic [NUM_POOLS-1:0] wrap_d;
	logic [IDX_W-1:0]    push_val;
	logic                mark_we;
	logic [MADDR_W-1:0]  mark_waddr;
	logic [MADDR_W-1:0]  mark_raddr;
	status_t             status_d;
	logic [POOL_W-1:0]   gpool_d;
	logic [FIDX_W-1:0]   gidx_d;

	assign advance   = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || advance;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(req.operation);
			size_s1 <= req.request_size;
			pool_s1 <= req.free_pool;
			idx_s1  <= req.free_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				limit_q[p] <= LIMIT_RESET[p];
			end
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_POOL0_BYTES: limit_q[0] <= cfg.data;
				REG_POOL1_BYTES: limit_q[1] <= cfg.data;
				REG_POOL2_BYTES: limit_q[2] <= cfg.data;
				REG_POOL3_BYTES: limit_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// pool selection and free check
	always_comb begin
		fit     = '0;
		pick    = '0;
		for (int p = 0; p < NUM_POOLS; p++) begin
			fit[p] = (size_s1 <= limit_q[p]) && (count_q[p] != '0);
		end
		for (int p = NUM_POOLS - 1; p >= 0; p--) begin
			if (fit[p]) begin
				pick = POOL_W'(p);
			end
		end
	end

	assign any_fit    = |fit;
	assign blk        = front[pick];
	assign fidx_ok    = (POOL_BLOCKS >= 2 ** FIDX_W) || (idx_s1 < FIDX_W'(MARK_BLOCKS));
	assign blk_marked = (POOL_BLOCKS <= 2 ** FIDX_W) || (blk < IDX_W'(MARK_BLOCKS));
	assign free_ok    = fidx_ok && mark_rd && (count_q[pool_s1] != FULL_CNT);
	assign push_val   = IDX_W'(idx_s1);

	always_comb begin
		for (int p = 0; p < NUM_POOLS; p++) begin
			pop_en[p]  = advance && (op_s1 == OP_ALLOC) && any_fit && (pick == POOL_W'(p));
			push_en[p] = advance && (op_s1 == OP_FREE) && free_ok && (pool_s1 == POOL_W'(p));
			head_d[p]  = head_q[p];
			tail_d[p]  = tail_q[p];
			count_d[p] = count_q[p];
			wrap_d[p]  = wrap_q[p];
			if (pop_en[p]) begin
				head_d[p]  = (head_q[p] == LAST_SLOT) ? '0 : head_q[p] + 1'b1;
				count_d[p] = count_q[p] - 1'b1;
			end
			if (push_en[p]) begin
				tail_d[p]  = (tail_q[p] == LAST_SLOT) ? '0 : tail_q[p] + 1'b1;
				count_d[p] = count_q[p] + 1'b1;
				wrap_d[p]  = wrap_q[p] || (tail_q[p] == LAST_SLOT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				head_q[p]  <= '0;
				tail_q[p]  <= '0;
				count_q[p] <= FULL_CNT;
			end
			wrap_q <= '0;
		end else begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				head_q[p]  <= head_d[p];
				tail_q[p]  <= tail_d[p];
				count_q[p] <= count_d[p];
			end
			wrap_q <= wrap_d;
		end
	end

	for (genvar g = 0; g < NUM_POOLS; g++) begin : g_bank
		sca_queue_bank #(
			.POOL_BLOCKS (POOL_BLOCKS)
		) u_bank (
			.clk   (clk),
			.we    (push_en[g]),
			.waddr (tail_q[g]),
			.wdata (push_val),
			.raddr (head_d[g]),
			.rinit (!(wrap_d[g] || (head_d[g] < tail_d[g]))),
			.rdata (front[g])
		);
	end

	// marks: set on grant, clear on successful free
	assign mark_we    = (|pop_en && blk_marked) || (|push_en);
	assign mark_waddr = (|pop_en) ? {pick, blk[MARK_W-1:0]} : {pool_s1, idx_s1[MARK_W-1:0]};
	assign mark_raddr = accept ? {req.free_pool, req.free_index[MARK_W-1:0]}
	                           : {pool_s1, idx_s1[MARK_W-1:0]};

	sca_mark_mem #(
		.ADDR_W (MADDR_W)
	) u_marks (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mark_we),
		.waddr  (mark_waddr),
		.wdata  (|pop_en),
		.raddr  (mark_raddr),
		.rdata  (mark_rd)
	);

	always_comb begin
		status_d = ST_NOT_ALLOC;
		gpool_d  = '0;
		gidx_d   = '0;
		if (op_s1 == OP_ALLOC) begin
			if (any_fit) begin
				status_d = ST_OK;
				gpool_d  = pick;
				gidx_d   = FIDX_W'(blk);
			end else begin
				status_d = ST_NO_BLOCK;
			end
		end else if (free_ok) begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			gpool_q  <= gpool_d;
			gidx_q   <= gidx_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_pool  = gpool_q;
	assign rsp.granted_index = gidx_q;

`ifndef SYNTHESIS
	a_one_list_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({pop_en, push_en}))
		else $error("more than one free list updated in a cycle");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp.valid)
		else $error("processed request produced no result");

	for (genvar g = 0; g < NUM_POOLS; g++) begin : g_chk
		a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
			((count_q[g] == FULL_CNT) || (count_q[g] == '0)) |-> (head_q[g] == tail_q[g]))
			else $error("free list pointers disagree with free count");
	end
`endif

endmodule
